[hdl/alerx_pkg.sv]
// shared constants, types and a helper function of the ascii line event receiver
package alerx_pkg;

    localparam int RING_DEPTH    = 128;
    localparam int LINE_CAPACITY = 32;

    localparam int RING_IDX_W = $clog2(RING_DEPTH);
    localparam int LINE_LEN_W = $clog2(LINE_CAPACITY);
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int EVT_LEN    = 14;
    localparam int EVT_IDX_W  = $clog2(EVT_LEN);

    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH    = 2'd0,
        MODE_SERVICE = 2'd1,
        MODE_TAKE    = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PARSE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_issue;
        logic parse;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ring_empty;
    } t_dp_stat;

    // "EVT,AUTO_START"
    function automatic logic [BYTE_W-1:0] evt_char(input logic [EVT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            4'd0:    c = "E";
            4'd1:    c = "V";
            4'd2:    c = "T";
            4'd3:    c = ",";
            4'd4:    c = "A";
            4'd5:    c = "U";
            4'd6:    c = "T";
            4'd7:    c = "O";
            4'd8:    c = "_";
            4'd9:    c = "S";
            4'd10:   c = "T";
            4'd11:   c = "A";
            4'd12:   c = "R";
            4'd13:   c = "T";
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

[hdl/alerx_ctrl.sv]
// controller state machine: sequences push, service drain, take, clear and result hand-off
module alerx_ctrl
    import alerx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_mode    i_mode,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == MODE_SERVICE) ? S_READ : S_FINISH;
                end
            end
            S_READ: begin
                n_state = i_stat.ring_empty ? S_FINISH : S_PARSE;
            end
            S_PARSE: begin
                n_state = S_READ;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.start    = i_in_valid;
            S_READ:   o_cmd.rd_issue = !i_stat.ring_empty;
            S_PARSE:  o_cmd.parse    = 1'b1;
            S_FINISH: o_cmd.out_load = !r_out_valid || !i_out_stall;
            default:  o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/alerx_dp.sv]
// datapath: byte ring, line tracker, event flag, enable register and result register
module alerx_dp
    import alerx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  t_mode               i_mode,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_byte_accepted,
    output logic                o_event_taken,
    output logic                o_event_pending,
    output logic [COUNT_W-1:0]  o_queued_count
);

    logic [BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic                  r_rx_en,     n_rx_en;
    logic [RING_IDX_W-1:0] r_wr_idx,    n_wr_idx;
    logic [RING_IDX_W-1:0] r_rd_idx,    n_rd_idx;
    logic                  r_overflow,  n_overflow;
    logic [LINE_LEN_W-1:0] r_line_len,  n_line_len;
    logic                  r_discard,   n_discard;
    logic                  r_prefix_ok, n_prefix_ok;
    logic                  r_zero_seen, n_zero_seen;
    logic [LINE_LEN_W-1:0] r_zero_pos,  n_zero_pos;
    logic [LINE_LEN_W-1:0] r_keep_len,  n_keep_len;
    logic                  r_pending,   n_pending;
    logic                  r_acc,       n_acc;
    logic                  r_taken,     n_taken;

    logic                  r_out_acc;
    logic                  r_out_taken;
    logic                  r_out_pending;
    logic [COUNT_W-1:0]    r_out_count;

    logic [RING_IDX_W-1:0] wr_next;
    logic [RING_IDX_W-1:0] rd_next;
    logic                  ring_we;
    logic [RING_IDX_W:0]   count;
    logic [LINE_LEN_W-1:0] eff_len;
    logic                  line_match;

    assign wr_next = (r_wr_idx == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    assign rd_next = (r_rd_idx == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;

    assign count = (r_wr_idx >= r_rd_idx)
                 ? ({1'b0, r_wr_idx} - {1'b0, r_rd_idx})
                 : ({1'b0, r_wr_idx} + (RING_IDX_W+1)'(RING_DEPTH) - {1'b0, r_rd_idx});

    assign o_stat.ring_empty = (r_rd_idx == r_wr_idx);

    // text length after trailing cr strip, cut at first zero
    assign eff_len    = r_zero_seen ? r_zero_pos : r_keep_len;
    assign line_match = r_prefix_ok && (eff_len == LINE_LEN_W'(EVT_LEN));

    assign ring_we = i_cmd.start && (i_mode == MODE_PUSH) && r_rx_en && (wr_next != r_rd_idx);

    always_comb begin
        n_rx_en     = r_rx_en;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_overflow  = r_overflow;
        n_line_len  = r_line_len;
        n_discard   = r_discard;
        n_prefix_ok = r_prefix_ok;
        n_zero_seen = r_zero_seen;
        n_zero_pos  = r_zero_pos;
        n_keep_len  = r_keep_len;
        n_pending   = r_pending;
        n_acc       = r_acc;
        n_taken     = r_taken;

        if (i_cfg_wr_en) begin
            n_rx_en = i_cfg_wr_data;
        end

        if (i_cmd.start) begin
            n_acc   = 1'b0;
            n_taken = 1'b0;
            unique case (i_mode)
                MODE_PUSH: begin
                    if (r_rx_en) begin
                        if (wr_next == r_rd_idx) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_wr_idx = wr_next;
                            n_acc    = 1'b1;
                        end
                    end
                end
                MODE_SERVICE: begin
                    if (r_overflow) begin
                        n_overflow  = 1'b0;
                        n_line_len  = '0;
                        n_prefix_ok = 1'b1;
                        n_zero_seen = 1'b0;
                        n_keep_len  = '0;
                        n_discard   = 1'b1;
                    end
                end
                MODE_TAKE: begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        n_taken   = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_pending = 1'b0;
                end
                default: n_pending = r_pending;
            endcase
        end

        if (i_cmd.rd_issue) begin
            n_rd_idx = rd_next;
        end

        if (i_cmd.parse) begin
            if (r_rd_data == CHAR_LF) begin
                if (!r_discard && line_match) begin
                    n_pending = 1'b1;
                end
                n_line_len  = '0;
                n_prefix_ok = 1'b1;
                n_zero_seen = 1'b0;
                n_keep_len  = '0;
                n_discard   = 1'b0;
            end else if (!r_discard) begin
                if (r_line_len < LINE_LEN_W'(LINE_CAPACITY - 1)) begin
                    if (r_line_len < LINE_LEN_W'(EVT_LEN)) begin
                        n_prefix_ok = r_prefix_ok
                                   && (r_rd_data == evt_char(r_line_len[EVT_IDX_W-1:0]));
                    end
                    if ((r_rd_data == CHAR_NUL) && !r_zero_seen) begin
                        n_zero_seen = 1'b1;
                        n_zero_pos  = r_line_len;
                    end
                    if (r_rd_data != CHAR_CR) begin
                        n_keep_len = r_line_len + 1'b1;
                    end
                    n_line_len = r_line_len + 1'b1;
                end else begin
                    n_line_len  = '0;
                    n_prefix_ok = 1'b1;
                    n_zero_seen = 1'b0;
                    n_keep_len  = '0;
                    n_discard   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en     <= 1'b1;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_overflow  <= 1'b0;
            r_line_len  <= '0;
            r_discard   <= 1'b0;
            r_prefix_ok <= 1'b1;
            r_zero_seen <= 1'b0;
            r_zero_pos  <= '0;
            r_keep_len  <= '0;
            r_pending   <= 1'b0;
            r_acc       <= 1'b0;
            r_taken     <= 1'b0;
        end else begin
            r_rx_en     <= n_rx_en;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_overflow  <= n_overflow;
            r_line_len  <= n_line_len;
            r_discard   <= n_discard;
            r_prefix_ok <= n_prefix_ok;
            r_zero_seen <= n_zero_seen;
            r_zero_pos  <= n_zero_pos;
            r_keep_len  <= n_keep_len;
            r_pending   <= n_pending;
            r_acc       <= n_acc;
            r_taken     <= n_taken;
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wr_idx] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_ring[r_rd_idx];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_acc     <= r_acc;
            r_out_taken   <= r_taken;
            r_out_pending <= r_pending;
            r_out_count   <= COUNT_W'(count);
        end
    end

    assign o_byte_accepted = r_out_acc;
    assign o_event_taken   = r_out_taken;
    assign o_event_pending = r_out_pending;
    assign o_queued_count  = r_out_count;

endmodule

[hdl/ascii_line_event_receiver_core.sv]
// top level of the ascii line event receiver: controller plus datapath
// Each transaction returns exactly one result. Push, take and clear hold the block in the
// accepting idle state and in a finish state that loads the result register; service also
// drains the N queued bytes, each with one registered ring read and one line tracker
// update, until a last read finds the ring empty, and then loads its result. The input is
// stalled while a transaction is in progress; a finished result waits in the output
// register and does not block acceptance of the next transaction, only the loading of its
// result, which waits while the output stays stalled. The ring keeps RING_DEPTH-1
// bytes; rx_enable resets to one.
module ascii_line_event_receiver_core
    import alerx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_byte_accepted,
    output logic               o_event_taken,
    output logic               o_event_pending,
    output logic [COUNT_W-1:0] o_queued_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_mode    mode;

    assign mode = t_mode'(i_mode);

    alerx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (mode),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    alerx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (mode),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_byte_accepted (o_byte_accepted),
        .o_event_taken   (o_event_taken),
        .o_event_pending (o_event_pending),
        .o_queued_count  (o_queued_count)
    );

endmodule

[hdl/alerx_chk.sv]
// port level checker for the ascii line event receiver and its bind
module alerx_chk
    import alerx_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_byte_accepted,
    input logic               o_event_taken,
    input logic               o_event_pending,
    input logic [COUNT_W-1:0] o_queued_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_accepted)
            && $stable(o_event_taken) && $stable(o_event_pending)
            && $stable(o_queued_count))
        else $error("result changed while stalled");

    // an accepted transaction stalls the input in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transaction");

    // a taken event is cleared in the same step
    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_event_taken && o_event_pending))
        else $error("event taken but still pending");

    // only one mode flag per result
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_byte_accepted && o_event_taken))
        else $error("push and take flags both set");

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind ascii_line_event_receiver_core alerx_chk u_alerx_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_byte_accepted (o_byte_accepted),
    .o_event_taken   (o_event_taken),
    .o_event_pending (o_event_pending),
    .o_queued_count  (o_queued_count)
);
